// File: rtl/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types and constants for the 3x3 stand edge detector.
// ----------------------------------------------------------------------------
package sed_pkg;

    localparam int HEIGHT_W    = 16;
    localparam int GRID_W      = 11;
    localparam int COLUMN_W    = 10;
    localparam int ROW_W       = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [HEIGHT_W-1:0] OUTSIDE_CODE     = 16'hFFFF;
    localparam logic [HEIGHT_W-1:0] THRESHOLD_RESET  = 16'd160;
    localparam logic [GRID_W-1:0]   GRID_WIDTH_RESET = 11'd1024;
    localparam logic [ROW_W-1:0]    ROW_MAX          = 16'hFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EDGE_THRESHOLD = 2'd0,
        CFG_GRID_WIDTH     = 2'd1
    } t_cfg_index;

endpackage

// File: rtl/sed_ram.sv
// ----------------------------------------------------------------------------
// sed_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sed_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/stand_edge_detect_3x3.sv
// ----------------------------------------------------------------------------
// stand_edge_detect_3x3
// Streaming 3x3 stand edge detector on a canopy height raster.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in row order, unless the result output stalls, and
// reports each interior pixel once its lower-right neighbour has arrived, one
// beat per reported pixel, through stage A and the result register. The
// previous two rows live in one RAM of MAX_WIDTH words, each word holding both
// rows for a column; the read for a pixel is issued as it is accepted, so a new
// pixel can be accepted while the last one is still in stage A. Columns are
// always written in order from zero, so a fill count stands in for the cleared
// reset state of the line store and no clearing pass is needed after reset.
module stand_edge_detect_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sed_pkg::HEIGHT_W-1:0]  i_height,
    input  logic                          i_frame_start,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_edge_res,
    output logic [sed_pkg::COLUMN_W-1:0]  o_column,
    output logic [sed_pkg::ROW_W-1:0]     o_row,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sed_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sed_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int HW = sed_pkg::HEIGHT_W;
    localparam int RW = sed_pkg::ROW_W;

    // configuration
    logic [HW-1:0]              r_thresh;
    logic [sed_pkg::GRID_W-1:0] r_grid;

    // position counters and line store fill count
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW:0]   r_fill;

    // stage A: pixel waiting for its line store data
    logic          r_a_valid;
    logic [HW-1:0] r_a_h;
    logic [CW-1:0] r_a_c;
    logic [RW-1:0] r_a_r;
    logic          r_a_rep;
    logic          r_rd_valid;
    logic          r_fwd;
    logic [2*HW-1:0] r_fwd_data;

    // 3x3 window: [0..2] column c-2 top/mid/bottom, [3..5] column c-1
    logic [HW-1:0] r_win [6];

    // result register
    logic                         r_out_valid;
    logic                         r_edge;
    logic [sed_pkg::COLUMN_W-1:0] r_column;
    logic [RW-1:0]                r_out_row;

    logic            in_fire;
    logic            a_fire;
    logic [CW:0]     w_eff;
    logic [CW-1:0]   c_in;
    logic [RW-1:0]   r_in;
    logic            row_end;
    logic            rep_in;
    logic [2*HW-1:0] ram_q;
    logic [2*HW-1:0] pair;
    logic [HW-1:0]   top;
    logic [HW-1:0]   mid;
    logic [HW-1:0]   ctr;
    logic [HW-1:0]   diff;
    logic [HW-1:0]   nb [8];
    logic            edge_hit;
    logic            n_edge;

    // effective width, clamped to [3, MAX_WIDTH]
    always_comb begin
        if (r_grid < sed_pkg::GRID_W'(3)) begin
            w_eff = (CW+1)'(3);
        end else if (32'(r_grid) > 32'(MAX_WIDTH)) begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (CW+1)'(r_grid);
        end
    end

    assign c_in    = i_frame_start ? '0 : r_col;
    assign r_in    = i_frame_start ? '0 : r_row;
    assign row_end = ({1'b0, c_in} + (CW+1)'(1)) >= w_eff;
    assign rep_in  = (c_in >= CW'(2)) && (r_in >= RW'(2)) && ({1'b0, c_in} < w_eff);

    assign a_fire     = r_a_valid && (!r_a_rep || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || a_fire;
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    sed_ram #(
        .WIDTH (2*HW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (a_fire),
        .i_waddr (r_a_c),
        .i_wdata ({mid, r_a_h}),
        .i_re    (in_fire),
        .i_raddr (c_in),
        .o_rdata (ram_q)
    );

    // unwritten columns read as zero; a write in the cycle of the read is forwarded
    always_comb begin
        if (r_fwd) begin
            pair = r_fwd_data;
        end else if (r_rd_valid) begin
            pair = ram_q;
        end else begin
            pair = '0;
        end
    end

    assign top = pair[2*HW-1:HW];
    assign mid = pair[HW-1:0];
    assign ctr = r_win[4];
    assign diff = ctr - r_thresh;

    assign nb[0] = r_win[0];
    assign nb[1] = r_win[1];
    assign nb[2] = r_win[2];
    assign nb[3] = r_win[3];
    assign nb[4] = r_win[5];
    assign nb[5] = top;
    assign nb[6] = mid;
    assign nb[7] = r_a_h;

    always_comb begin
        edge_hit = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (nb[k] < diff) begin
                edge_hit = 1'b1;
            end
        end
    end

    assign n_edge = (ctr != sed_pkg::OUTSIDE_CODE) && (ctr > r_thresh) && edge_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= sed_pkg::THRESHOLD_RESET;
            r_grid      <= sed_pkg::GRID_WIDTH_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_fill      <= '0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sed_pkg::CFG_EDGE_THRESHOLD: r_thresh <= i_cfg_data;
                    sed_pkg::CFG_GRID_WIDTH:     r_grid   <= i_cfg_data[sed_pkg::GRID_W-1:0];
                    default: ;
                endcase
            end

            if (in_fire) begin
                if (row_end) begin
                    r_col <= '0;
                    if (r_in != sed_pkg::ROW_MAX) begin
                        r_row <= r_in + RW'(1);
                    end else begin
                        r_row <= r_in;
                    end
                end else begin
                    r_col <= c_in + CW'(1);
                    r_row <= r_in;
                end
            end

            if (in_fire) begin
                r_a_valid <= 1'b1;
            end else if (a_fire) begin
                r_a_valid <= 1'b0;
            end

            if (a_fire) begin
                if ({1'b0, r_a_c} == r_fill) begin
                    r_fill <= r_fill + (CW+1)'(1);
                end
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top;
                r_win[4] <= mid;
                r_win[5] <= r_a_h;
            end

            if (a_fire && r_a_rep) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_h      <= i_height;
            r_a_c      <= c_in;
            r_a_r      <= r_in;
            r_a_rep    <= rep_in;
            r_rd_valid <= {1'b0, c_in} < r_fill;
            r_fwd      <= a_fire && (r_a_c == c_in);
            r_fwd_data <= {mid, r_a_h};
        end
        if (a_fire && r_a_rep) begin
            r_edge    <= n_edge;
            r_column  <= sed_pkg::COLUMN_W'(r_a_c - CW'(1));
            r_out_row <= r_a_r - RW'(1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_edge_res  = r_edge;
    assign o_column    = r_column;
    assign o_row       = r_out_row;

endmodule
